>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define OKVT_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A trigger that must be followed by a condition in the next cycle.
`define OKVT_ASSERT_NEXT(lbl, trig, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) else $error(msg);

`endif

>>> sv/okvt_pkg.sv
// ----------------------------------------------------------------------------
// okvt_pkg
// Types, operation and status codes shared by the ordered key/value table.
// ----------------------------------------------------------------------------
package okvt_pkg;

  localparam int OKVT_CAPACITY = 16;
  localparam int KEY_W         = 32;
  localparam int VAL_W         = 32;
  localparam int OP_W          = 3;
  localparam int STATUS_W      = 2;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic        [VAL_W-1:0] val_t;

  // Operation codes carried by an input beat.
  typedef enum logic [OP_W-1:0] {
    OP_INSERT     = 3'd0,
    OP_LOOKUP     = 3'd1,
    OP_REMOVE     = 3'd2,
    OP_ITER_RESET = 3'd3,
    OP_ITER_NEXT  = 3'd4,
    OP_ITER_READ  = 3'd5
  } op_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // Command broadcast from the control logic to every cell.
  typedef struct packed {
    logic update_en;  // overwrite the value in the matching cell
    logic append_en;  // load key and value into the tail cell
    logic remove_en;  // cells at and after the match take their neighbor's entry
    key_t key;
    val_t value;
  } okvt_cmd_t;

endpackage

>>> sv/okvt_in_if.sv
// ----------------------------------------------------------------------------
// okvt_in_if
// Input channel: one operation beat with op, key and value.
// ----------------------------------------------------------------------------
interface okvt_in_if
  import okvt_pkg::*;
();
  logic        valid;
  logic        ready;
  logic [OP_W-1:0] op;
  key_t        key;
  val_t        value;

  modport source (output valid, output op, output key, output value, input ready);
  modport sink   (input valid, input op, input key, input value, output ready);
endinterface

>>> sv/okvt_out_if.sv
// ----------------------------------------------------------------------------
// okvt_out_if
// Result channel: status, iterator key and value, entry count and end flag.
// ----------------------------------------------------------------------------
interface okvt_out_if
  import okvt_pkg::*;
#(
  parameter int CNT_W = $clog2(OKVT_CAPACITY + 1)
) ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  key_t                out_key;
  val_t                out_value;
  logic [CNT_W-1:0]    entry_count;
  logic                iter_done;

  modport source (output valid, output status, output out_key, output out_value,
                  output entry_count, output iter_done, input ready);
  modport sink   (input valid, input status, input out_key, input out_value,
                  input entry_count, input iter_done, output ready);
endinterface

>>> sv/ordered_key_value_table.sv
// ----------------------------------------------------------------------------
// ordered_key_value_table
// Insertion-ordered key/value table built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// In each operation all cells compare the key at once,
// a remove shifts the entries after the match one place toward the head, and
// the result is registered, appearing the cycle after the input beat is taken.
// A new beat is taken whenever the result register is empty or being drained
// in the same cycle, so with the result side always ready the table sustains
// one operation per clock. The row of CAPACITY cells sets the storage; the
// key compare and the hit ripple across the row set the cycle's logic depth.
// Keys are unique in the table, so at most one cell ever matches.
`include "assert_macros.svh"

module ordered_key_value_table
  import okvt_pkg::*;
#(
  parameter int CAPACITY = OKVT_CAPACITY
) (
  input  logic       clk,
  input  logic       rst_n,
  okvt_in_if.sink    in_ch,
  okvt_out_if.source out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] iter_r, iter_nxt;

  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r, status_nxt;
  key_t                okey_r, okey_nxt;
  val_t                oval_r, oval_nxt;
  logic [CNT_W-1:0]    ocount_r;
  logic                odone_r;

  logic      fire;
  op_e       op_sel;
  okvt_cmd_t cmd;
  logic      any_hit;
  logic      iter_valid;
  logic      append_ok;
  logic      remove_ok;

  logic [CAPACITY:0]   hit_chain;
  logic [CAPACITY-1:0] match_vec;
  logic [CAPACITY-1:0] iter_here;
  key_t cell_key   [CAPACITY];
  val_t cell_value [CAPACITY];
  key_t nbr_key    [CAPACITY];
  val_t nbr_value  [CAPACITY];
  val_t hit_value;
  key_t iter_key;
  val_t iter_value;

  // Input is taken when the result register is free or draining.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign fire        = in_ch.valid && in_ch.ready;
  assign op_sel      = op_e'(in_ch.op);

  // Row of cells; the hit flag enters at the head and leaves at the tail.
  assign hit_chain[0] = 1'b0;
  assign any_hit      = hit_chain[CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == CAPACITY - 1) begin : g_last
      assign nbr_key[i]   = '0;
      assign nbr_value[i] = '0;
    end else begin : g_mid
      assign nbr_key[i]   = cell_key[i+1];
      assign nbr_value[i] = cell_value[i+1];
    end

    assign iter_here[i] = (iter_r == CNT_W'(i));

    okvt_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occupied  (CNT_W'(i) < count_r),
      .is_tail   (CNT_W'(i) == count_r),
      .hit_in    (hit_chain[i]),
      .nbr_key   (nbr_key[i]),
      .nbr_value (nbr_value[i]),
      .match     (match_vec[i]),
      .hit_out   (hit_chain[i+1]),
      .key_q     (cell_key[i]),
      .value_q   (cell_value[i])
    );
  end

  // One-hot selection of the matching cell and of the iterator's cell.
  always_comb begin
    hit_value  = '0;
    iter_key   = '0;
    iter_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match_vec[i]) begin
        hit_value = hit_value | cell_value[i];
      end
      if (iter_here[i]) begin
        iter_key   = iter_key | cell_key[i];
        iter_value = iter_value | cell_value[i];
      end
    end
  end

  // Commands to the cells.
  assign iter_valid = iter_r < count_r;
  assign append_ok  = !any_hit && (count_r != CAP_C);
  assign remove_ok  = any_hit;

  always_comb begin
    cmd.update_en = fire && (op_sel == OP_INSERT) && any_hit;
    cmd.append_en = fire && (op_sel == OP_INSERT) && append_ok;
    cmd.remove_en = fire && (op_sel == OP_REMOVE) && remove_ok;
    cmd.key       = in_ch.key;
    cmd.value     = in_ch.value;
  end

  // Next count, iterator and result fields for the current beat.
  always_comb begin
    count_nxt  = count_r;
    iter_nxt   = iter_r;
    status_nxt = ST_OK;
    okey_nxt   = '0;
    oval_nxt   = '0;
    case (op_sel)
      OP_INSERT: begin
        if (!any_hit) begin
          if (count_r == CAP_C) begin
            status_nxt = ST_FULL;
          end else begin
            count_nxt = count_r + ONE_C;
          end
        end
      end
      OP_LOOKUP: begin
        if (any_hit) begin
          oval_nxt = hit_value;
        end else begin
          status_nxt = ST_MISS;
        end
      end
      OP_REMOVE: begin
        if (any_hit) begin
          count_nxt = count_r - ONE_C;
          if (iter_r >= count_nxt) begin
            iter_nxt = CAP_C;
          end
        end else begin
          status_nxt = ST_MISS;
        end
      end
      OP_ITER_RESET: begin
        if (count_r == '0) begin
          iter_nxt   = CAP_C;
          status_nxt = ST_MISS;
        end else begin
          iter_nxt = '0;
        end
      end
      OP_ITER_NEXT: begin
        if (iter_valid && ((iter_r + ONE_C) < count_r)) begin
          iter_nxt = iter_r + ONE_C;
        end else begin
          iter_nxt   = CAP_C;
          status_nxt = ST_MISS;
        end
      end
      OP_ITER_READ: begin
        if (iter_valid) begin
          okey_nxt = iter_key;
          oval_nxt = iter_value;
        end else begin
          status_nxt = ST_MISS;
        end
      end
      default: begin
      end
    endcase
  end

  // Table control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      iter_r  <= CAP_C;
    end else if (fire) begin
      count_r <= count_nxt;
      iter_r  <= iter_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r <= status_nxt;
      okey_r   <= okey_nxt;
      oval_r   <= oval_nxt;
      ocount_r <= count_nxt;
      odone_r  <= !(iter_nxt < count_nxt);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.out_key     = okey_r;
  assign out_ch.out_value   = oval_r;
  assign out_ch.entry_count = ocount_r;
  assign out_ch.iter_done   = odone_r;

  // Checks on the table's own bookkeeping.
  `OKVT_ASSERT_ALWAYS(a_count_range, count_r <= CAP_C, "entry count above capacity")
  `OKVT_ASSERT_ALWAYS(a_iter_range, (iter_r < count_r) || (iter_r == CAP_C), "iterator stale")
  `OKVT_ASSERT_ALWAYS(a_one_match, $onehot0(match_vec), "more than one cell matches the key")
  `OKVT_ASSERT_NEXT(a_full_hold, cmd.append_en && (count_r == CAP_C - ONE_C), count_r == CAP_C, "append lost")
  `OKVT_ASSERT_NEXT(a_remove_count, cmd.remove_en, count_r == $past(count_r) - ONE_C, "remove did not shrink table")

endmodule

>>> sv/okvt_cell.sv
// ----------------------------------------------------------------------------
// okvt_cell
// One table slot: holds a key and a value, compares against the broadcast
// key, and takes its right neighbor's entry when a remove closes a gap.
// ----------------------------------------------------------------------------
module okvt_cell
  import okvt_pkg::*;
(
  input  logic      clk,
  input  okvt_cmd_t cmd,
  input  logic      occupied,
  input  logic      is_tail,
  input  logic      hit_in,
  input  key_t      nbr_key,
  input  val_t      nbr_value,
  output logic      match,
  output logic      hit_out,
  output key_t      key_q,
  output val_t      value_q
);

  key_t key_r;
  val_t value_r;

  // Only occupied slots can match; the hit flag ripples toward the tail.
  assign match   = occupied && (key_r == cmd.key);
  assign hit_out = hit_in || match;
  assign key_q   = key_r;
  assign value_q = value_r;

  // Shift on remove, load on append, overwrite the value on update.
  always_ff @(posedge clk) begin
    if (cmd.remove_en && hit_out) begin
      key_r   <= nbr_key;
      value_r <= nbr_value;
    end else if (cmd.append_en && is_tail) begin
      key_r   <= cmd.key;
      value_r <= cmd.value;
    end else if (cmd.update_en && match) begin
      value_r <= cmd.value;
    end
  end

endmodule

>>> bench/okvt_result_checker.sv
// ----------------------------------------------------------------------------
// okvt_result_checker
// Watches both channels of the table, predicts every result and compares it.
// ----------------------------------------------------------------------------
// Each accepted input beat runs through a behavioral copy of the table. The
// copy holds the ordered entries, the fill level and the iterator position.
// The predicted result is queued, and each accepted result beat is checked
// field by field against the oldest entry in that queue.
module okvt_result_checker
  import okvt_pkg::*;
#(
  parameter int CNT_W = $clog2(OKVT_CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [OP_W-1:0]     in_op,
  input  key_t                in_key,
  input  val_t                in_value,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [STATUS_W-1:0] out_status,
  input  key_t                out_key,
  input  val_t                out_value,
  input  logic [CNT_W-1:0]    out_entry_count,
  input  logic                out_iter_done,
  output int                  error_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // The iterator position that stands for null.
  localparam int ITER_NULL = OKVT_CAPACITY;
  // Only the first mismatches are printed; all of them are counted.
  localparam int PRINT_LIMIT = 100;

  typedef struct {
    status_e          status;
    key_t             key;
    val_t             value;
    logic [CNT_W-1:0] count;
    logic             iter_done;
  } table_result_t;

  // Shadow copy of the table contents.
  key_t slot_key [OKVT_CAPACITY];
  val_t slot_val [OKVT_CAPACITY];
  int   fill_level = 0;
  int   cursor     = ITER_NULL;

  table_result_t expected_q[$];
  int errs        = 0;
  int queued      = 0;
  int results_seen = 0;

  assign error_count = errs;
  assign pending     = queued;

  task automatic report_mismatch(input string what);
    if (errs < PRINT_LIMIT) begin
      $display("[%0t] MISMATCH: %s", $realtime, what);
    end
    errs++;
  endtask

  // Applies one operation to the shadow table and returns its result.
  function automatic table_result_t apply_op(input logic [OP_W-1:0] op, input key_t k,
                                             input val_t v);
    table_result_t r;
    int hit;
    hit         = -1;
    r.status    = ST_OK;
    r.key       = '0;
    r.value     = '0;
    for (int i = 0; i < fill_level; i++) begin
      if (hit < 0 && slot_key[i] == k) hit = i;
    end
    case (op)
      OP_INSERT: begin
        if (hit >= 0) begin
          slot_val[hit] = v;
        end else if (fill_level >= OKVT_CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          slot_key[fill_level] = k;
          slot_val[fill_level] = v;
          fill_level++;
        end
      end
      OP_LOOKUP: begin
        if (hit >= 0) r.value = slot_val[hit];
        else r.status = ST_MISS;
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          // Entries behind the match move one place toward the head.
          for (int i = hit; i + 1 < fill_level; i++) begin
            slot_key[i] = slot_key[i + 1];
            slot_val[i] = slot_val[i + 1];
          end
          fill_level--;
          if (cursor >= fill_level) cursor = ITER_NULL;
        end else begin
          r.status = ST_MISS;
        end
      end
      OP_ITER_RESET: begin
        cursor   = (fill_level == 0) ? ITER_NULL : 0;
        r.status = (cursor < fill_level) ? ST_OK : ST_MISS;
      end
      OP_ITER_NEXT: begin
        if (cursor < fill_level) begin
          cursor++;
          if (cursor >= fill_level) cursor = ITER_NULL;
        end else begin
          cursor = ITER_NULL;
        end
        r.status = (cursor < fill_level) ? ST_OK : ST_MISS;
      end
      OP_ITER_READ: begin
        if (cursor < fill_level) begin
          r.key   = slot_key[cursor];
          r.value = slot_val[cursor];
        end else begin
          r.status = ST_MISS;
        end
      end
      default: begin
        // Spare op codes leave the table untouched.
      end
    endcase
    r.count     = fill_level[CNT_W-1:0];
    r.iter_done = !(cursor < fill_level);
    return r;
  endfunction

  task automatic check_result(input table_result_t want);
    if (out_status !== want.status)
      report_mismatch($sformatf("result %0d status: got %0d expected %0d",
                                results_seen, out_status, want.status));
    if (out_key !== want.key)
      report_mismatch($sformatf("result %0d out_key: got %h expected %h",
                                results_seen, out_key, want.key));
    if (out_value !== want.value)
      report_mismatch($sformatf("result %0d out_value: got %h expected %h",
                                results_seen, out_value, want.value));
    if (out_entry_count !== want.count)
      report_mismatch($sformatf("result %0d entry_count: got %0d expected %0d",
                                results_seen, out_entry_count, want.count));
    if (out_iter_done !== want.iter_done)
      report_mismatch($sformatf("result %0d iter_done: got %b expected %b",
                                results_seen, out_iter_done, want.iter_done));
  endtask

  // Predict on every accepted input beat, check on every accepted result beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      fill_level = 0;
      cursor     = ITER_NULL;
      expected_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        expected_q.push_back(apply_op(in_op, in_key, in_value));
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected",
                                    results_seen));
        end else begin
          check_result(expected_q.pop_front());
        end
        results_seen++;
      end
    end
    queued = expected_q.size();
  end

endmodule

>>> bench/ordered_key_value_table_tb.sv
// ----------------------------------------------------------------------------
// ordered_key_value_table_tb
// Stimulus and verdict for the ordered key/value table.
// ----------------------------------------------------------------------------
// A directed opening fills the table from empty through full with extreme
// keys and values, and touches every iterator case. Random traffic then
// alternates between fill-heavy, drain-heavy and mixed phases, with frequent
// iterator walks, over a small key pool so that hits, updates and full
// inserts are common. Both channel sides idle and stall at random.
module ordered_key_value_table_tb
  import okvt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  CLK_PERIOD   = 20;
  localparam int  RESET_CYCLES = 12;
  localparam int  RANDOM_BEATS = 1350;
  localparam int  POOL_SIZE    = 24;
  localparam int  DRAIN_CYCLES = 8;
  localparam int  CYCLE_LIMIT  = 400000;
  localparam int  PHASE_BEATS  = 120;
  // Op codes the table does not define; it must ignore them.
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  // Traffic phases of the random part.
  typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_e;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  okvt_in_if  in_ch ();
  okvt_out_if out_ch ();

  int   error_count;
  int   pending;
  int   cycle_count = 0;
  int   beats_sent  = 0;
  bit   in_burst    = 1'b0;
  bit   out_burst   = 1'b0;
  key_t key_pool [POOL_SIZE];

  ordered_key_value_table #(.CAPACITY(OKVT_CAPACITY)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  okvt_result_checker result_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_op           (in_ch.op),
    .in_key          (in_ch.key),
    .in_value        (in_ch.value),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_key         (out_ch.out_key),
    .out_value       (out_ch.out_value),
    .out_entry_count (out_ch.entry_count),
    .out_iter_done   (out_ch.iter_done),
    .error_count     (error_count),
    .pending         (pending)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: stall a random number of cycles before taking each beat.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = out_burst ? 0 : ($urandom_range(0, 1) ? 0 : $urandom_range(0, 13));
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
    end
  end

  // Drives one input beat after a random gap and waits until it is taken.
  task automatic send_beat(input logic [OP_W-1:0] op, input key_t k, input val_t v);
    int gap;
    gap = in_burst ? 0 : ($urandom_range(0, 1) ? 0 : $urandom_range(0, 13));
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.key   <= k;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
  endtask

  // Mostly pool keys; off-pool keys are only used where a miss is harmless.
  function automatic key_t pick_key(input bit allow_stray);
    if (allow_stray && $urandom_range(0, 9) == 0) return $urandom;
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic val_t pick_value();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Iterator walk: reset, then reads, advances and removes, sometimes past the end.
  task automatic iter_walk();
    int steps;
    steps = $urandom_range(0, 20);
    send_beat(OP_ITER_RESET, $urandom, $urandom);
    repeat (steps) begin
      case ($urandom_range(0, 4))
        0, 1:    send_beat(OP_ITER_READ, $urandom, $urandom);
        2, 3:    send_beat(OP_ITER_NEXT, $urandom, $urandom);
        default: send_beat(OP_REMOVE, pick_key(1'b0), $urandom);
      endcase
    end
  endtask

  // One random operation, weighted by the current phase.
  task automatic random_beat(input phase_e ph);
    int w_ins;
    int w_look;
    int w_rem;
    int r;
    case (ph)
      PH_FILL:  begin w_ins = 55; w_look = 15; w_rem = 8;  end
      PH_DRAIN: begin w_ins = 15; w_look = 20; w_rem = 40; end
      default:  begin w_ins = 30; w_look = 20; w_rem = 15; end
    endcase
    r = $urandom_range(0, 99);
    if (r < w_ins) begin
      send_beat(OP_INSERT, pick_key(1'b0), pick_value());
    end else if (r < w_ins + w_look) begin
      send_beat(OP_LOOKUP, pick_key(1'b1), $urandom);
    end else if (r < w_ins + w_look + w_rem) begin
      send_beat(OP_REMOVE, pick_key(1'b1), $urandom);
    end else if (r < 97) begin
      case ($urandom_range(0, 2))
        0:       send_beat(OP_ITER_RESET, $urandom, $urandom);
        1:       send_beat(OP_ITER_NEXT, $urandom, $urandom);
        default: send_beat(OP_ITER_READ, $urandom, $urandom);
      endcase
    end else begin
      send_beat($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B, $urandom, $urandom);
    end
  endtask

  // Main stimulus.
  initial begin
    phase_e ph;
    int     random_start;
    in_ch.valid <= 1'b0;
    in_ch.op    <= OP_INSERT;
    in_ch.key   <= '0;
    in_ch.value <= '0;

    // The two extreme keys together give every key bit both values.
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table: iterator and removal cases.
    send_beat(OP_ITER_READ, 32'h0, 32'h0);
    send_beat(OP_ITER_RESET, 32'h0, 32'h0);
    send_beat(OP_ITER_NEXT, 32'h0, 32'h0);
    send_beat(OP_REMOVE, key_pool[1], 32'h0);

    // Fill to capacity, with extreme values on the first two entries.
    for (int i = 0; i < OKVT_CAPACITY; i++) begin
      send_beat(OP_INSERT, key_pool[i],
                (i == 0) ? 32'h0000_0000 : (i == 1) ? 32'hffff_ffff : $urandom);
    end
    // Full: a new key is refused, a present key is still updated.
    send_beat(OP_INSERT, key_pool[OKVT_CAPACITY], $urandom);
    send_beat(OP_INSERT, key_pool[1], 32'h3f80_0000);
    send_beat(OP_LOOKUP, key_pool[1], 32'h0);

    // Iterator over a full table, then removal of the head under it.
    send_beat(OP_ITER_RESET, 32'h0, 32'h0);
    send_beat(OP_ITER_READ, 32'h0, 32'h0);
    send_beat(OP_ITER_NEXT, 32'h0, 32'h0);
    send_beat(OP_REMOVE, key_pool[0], 32'h0);
    send_beat(OP_ITER_READ, 32'h0, 32'h0);
    send_beat(OP_SPARE_A, 32'hffff_ffff, 32'hffff_ffff);
    send_beat(OP_SPARE_B, 32'h0, 32'h0);

    // Random traffic in phases, each with its own idling style.
    random_start = beats_sent;
    ph = PH_MIX;
    while (beats_sent - random_start < RANDOM_BEATS) begin
      if ((beats_sent - random_start) % PHASE_BEATS == 0) begin
        ph        = phase_e'($urandom_range(0, 2));
        in_burst  = ($urandom_range(0, 3) == 0);
        out_burst = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 4) == 0) iter_walk();
      else random_beat(ph);
    end

    // Wait for every outstanding result, then a short drain.
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
